// ----- src/pqra_pkg.sv -----
// Package for the packet queue admission block: sizes, codes and state type.
// Used by the top module under src; the divider needs nothing from it.
package pqra_pkg;

  localparam int NumQueues = 8;
  localparam int RingDepth = 64;
  localparam int QW = 3;
  localparam int PW = $clog2(RingDepth);
  localparam int CW = $clog2(RingDepth + 1);
  localparam int AW = QW + PW;
  localparam logic [23:0] ByteMax = 24'hFFFFFF;
  localparam logic [15:0] LfsrSeed = 16'hACE1;
  localparam logic [15:0] LfsrTaps = 16'hB400;

  localparam logic [1:0] OpEnq = 2'd0;
  localparam logic [1:0] OpDeqNamed = 2'd1;
  localparam logic [1:0] OpDeqPrio = 2'd2;
  localparam logic [1:0] OpUnused = 2'd3;

  localparam logic [1:0] PolUnlim = 2'd0;
  localparam logic [1:0] PolTail = 2'd1;
  localparam logic [1:0] PolRed = 2'd2;
  localparam logic [1:0] PolToken = 2'd3;

  localparam logic [2:0] StAccepted = 3'd0;
  localparam logic [2:0] StLimitDrop = 3'd1;
  localparam logic [2:0] StEarlyDrop = 3'd2;
  localparam logic [2:0] StRingFull = 3'd3;
  localparam logic [2:0] StDequeued = 3'd4;
  localparam logic [2:0] StEmpty = 3'd5;

  localparam logic [2:0] RegPolicy = 3'd0;
  localparam logic [2:0] RegLimit = 3'd1;
  localparam logic [2:0] RegMin = 3'd2;
  localparam logic [2:0] RegMax = 3'd3;
  localparam logic [2:0] RegProb = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_DECIDE, S_READ, S_OUT
  } state_t;

endpackage

// ----- src/pqra_div.sv -----
// Bit-serial restoring divider for the early-detection drop chance.
// Stands alone; it needs nothing from the package.
module pqra_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [39:0] dividend,
  input  logic [23:0] divisor,
  output logic        done,
  output logic [39:0] quotient
);

  logic [5:0]  count;
  logic        busy;
  logic [24:0] rem;
  logic [24:0] trial;

  assign trial = {rem[23:0], quotient[39]} - {1'b0, divisor};

  // One quotient bit per cycle while busy, until all dividend bits are done.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= 6'd0;
        rem <= '0;
        quotient <= dividend;
      end else if (busy) begin
        if (!trial[24]) begin
          rem <= trial;
          quotient <= {quotient[38:0], 1'b1};
        end else begin
          rem <= {rem[23:0], quotient[39]};
          quotient <= {quotient[38:0], 1'b0};
        end
        count <= count + 6'd1;
        if (count == 6'd39) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- src/packet_queue_red_admission_top.sv -----
// Top level of the packet queue manager with shared drop policy.
// Depends on pqra_pkg and pqra_div.
//
// Channel | direction | handshake
// in      | input     | in_valid / in_stall
// out     | output    | out_valid / out_stall
// cfg     | input     | cfg_valid / cfg_ready
//
// An item passes through accept, decide, ring memory read and output; an
// early-detection chance between the limits adds a wait on the serial
// divider. One item at a time is in work. The output register holds a result
// under out_stall; the next input is stalled until it leaves. Reset is
// synchronous; the rings need no clearing pass.
module packet_queue_red_admission_top import pqra_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [2:0]  queue_index,
  input  logic [15:0] packet_handle,
  input  logic [15:0] packet_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [15:0] out_handle,
  output logic [15:0] out_length,
  output logic [2:0]  out_queue,
  output logic [23:0] queue_byte_count,
  output logic [31:0] limit_drop_total,
  output logic [31:0] early_drop_total,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [1:0]  drop_policy;
  logic [23:0] byte_limit, red_min, red_max;
  logic [15:0] red_prob;

  logic [15:0] mem_h [NumQueues*RingDepth];
  logic [15:0] mem_l [NumQueues*RingDepth];
  logic [15:0] rd_h, rd_l;

  logic [PW-1:0] heads [NumQueues];
  logic [CW-1:0] counts [NumQueues];
  logic [23:0]   bytes [NumQueues];
  logic [31:0]   limit_drops, early_drops;
  logic [15:0]   lfsr;

  state_t state, state_next;
  logic [1:0]  r_op;
  logic [2:0]  r_q;
  logic [15:0] r_h, r_l;
  logic        r_deq;
  logic        r_found;
  logic [2:0]  r_stat;
  logic [2:0]  sq;
  logic        div_start;
  logic        div_done;
  logic [39:0] quot;
  logic [15:0] lfsr_adv;

  assign cfg_ready = 1'b1;
  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      drop_policy <= PolUnlim;
      byte_limit <= ByteMax;
      red_min <= '0;
      red_max <= ByteMax;
      red_prob <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        RegPolicy: drop_policy <= cfg_data[1:0];
        RegLimit:  byte_limit <= cfg_data[23:0];
        RegMin:    red_min <= cfg_data[23:0];
        RegMax:    red_max <= cfg_data[23:0];
        RegProb:   red_prob <= cfg_data[15:0];
        default:   ;
      endcase
    end
  end

  // Strict-priority search over the entry counts.
  always_comb begin
    sq = '0;
    r_found = 1'b0;
    for (int i = NumQueues - 1; i >= 0; i--) begin
      if (counts[i] != '0) begin
        sq = QW'(i);
        r_found = 1'b1;
      end
    end
  end

  logic [23:0] occ;
  logic        in_range;
  assign in_range = (32'(r_q) < NumQueues);
  assign occ = bytes[r_q];
  assign lfsr_adv = lfsr[0] ? ((lfsr >> 1) ^ LfsrTaps) : (lfsr >> 1);

  pqra_div u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend(40'(red_prob) * 40'(occ - red_min)),
    .divisor(red_max - red_min), .done(div_done), .quotient(quot)
  );

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid && !in_stall) state_next = S_DECIDE;
      S_DECIDE: begin
        if (r_op == OpEnq && in_range && drop_policy == PolRed &&
            occ >= red_min && occ < red_max)
          state_next = S_DIV;
        else
          state_next = S_READ;
      end
      S_DIV:    if (div_done) state_next = S_READ;
      S_READ:   state_next = S_OUT;
      S_OUT:    state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Divider start control.
  always_comb begin
    div_start = (state == S_DECIDE) && (state_next == S_DIV);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // Datapath: decide, update state, read and write the rings.
  always_ff @(posedge clk) begin
    logic [AW-1:0] wa;
    logic [24:0]   sum;
    logic [15:0]   pr;
    if (rst) begin
      for (int i = 0; i < NumQueues; i++) begin
        heads[i] <= '0;
        counts[i] <= '0;
        bytes[i] <= '0;
      end
      limit_drops <= '0;
      early_drops <= '0;
      lfsr <= LfsrSeed;
      out_valid <= 1'b0;
      r_stat <= StEmpty;
      r_deq <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (state == S_IDLE && in_valid && !in_stall) begin
        r_op <= operation;
        r_q <= queue_index;
        r_h <= packet_handle;
        r_l <= packet_length;
      end
      if (state == S_DECIDE || (state == S_DIV && div_done)) begin
        pr = (state == S_DIV) ? quot[15:0] : red_prob;
        sum = {1'b0, occ} + 25'(r_l);
        wa = {r_q, PW'(32'(heads[r_q]) + 32'(counts[r_q]))};
        if (r_op == OpEnq) begin
          r_deq <= 1'b0;
          if (!in_range) begin
            r_stat <= StRingFull;
          end else if (drop_policy != PolUnlim && drop_policy != PolRed &&
                       occ >= byte_limit) begin
            r_stat <= StLimitDrop;
          end else if (drop_policy == PolRed && occ >= red_min &&
                       occ >= red_max && occ >= byte_limit) begin
            r_stat <= StLimitDrop;
          end else if (state == S_DECIDE && drop_policy == PolRed &&
                       occ >= red_min && occ < red_max) begin
            r_stat <= StEmpty;
          end else if (drop_policy == PolRed && occ >= red_min &&
                       lfsr_adv < pr) begin
            r_stat <= StEarlyDrop;
          end else if (32'(counts[r_q]) >= RingDepth) begin
            r_stat <= StRingFull;
          end else if (sum[24]) begin
            r_stat <= StLimitDrop;
          end else begin
            r_stat <= StAccepted;
            mem_h[wa] <= r_h;
            mem_l[wa] <= r_l;
            counts[r_q] <= counts[r_q] + CW'(1);
            bytes[r_q] <= sum[23:0];
          end
          if (drop_policy == PolRed && occ >= red_min && in_range &&
              !(occ >= red_max && occ >= byte_limit) &&
              !(state == S_DECIDE && occ < red_max))
            lfsr <= lfsr_adv;
        end else if (r_op == OpDeqNamed) begin
          r_stat <= StEmpty;
          r_deq <= in_range && counts[r_q] != '0;
        end else if (r_op == OpDeqPrio) begin
          r_stat <= StEmpty;
          r_q <= sq;
          r_deq <= r_found;
        end else begin
          r_stat <= StEmpty;
          r_deq <= 1'b0;
        end
      end
      if (state == S_READ) begin
        rd_h <= mem_h[{r_q, heads[r_q]}];
        rd_l <= mem_l[{r_q, heads[r_q]}];
        if (r_stat == StLimitDrop || r_stat == StRingFull) begin
          if (limit_drops != '1) limit_drops <= limit_drops + 32'd1;
        end
        if (r_stat == StEarlyDrop && early_drops != '1)
          early_drops <= early_drops + 32'd1;
      end
      if (state == S_OUT) begin
        out_valid <= 1'b1;
        limit_drop_total <= limit_drops;
        early_drop_total <= early_drops;
        if (r_deq) begin
          status <= StDequeued;
          out_handle <= rd_h;
          out_length <= rd_l;
          out_queue <= r_q;
          heads[r_q] <= PW'(32'(heads[r_q]) + 1);
          counts[r_q] <= counts[r_q] - CW'(1);
          bytes[r_q] <= (bytes[r_q] >= 24'(rd_l)) ? bytes[r_q] - 24'(rd_l) : '0;
          queue_byte_count <= (bytes[r_q] >= 24'(rd_l)) ?
                              bytes[r_q] - 24'(rd_l) : '0;
        end else begin
          status <= r_stat;
          out_handle <= '0;
          out_length <= '0;
          if (r_op == OpDeqPrio) begin
            out_queue <= '0;
            queue_byte_count <= '0;
          end else begin
            out_queue <= r_q;
            queue_byte_count <= in_range ? bytes[r_q] : '0;
          end
        end
      end
    end
  end

  // Checks on the sequencer.
  a_no_out_overrun: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> !(out_valid && out_stall)) else $error("output overrun");
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV) else $error("stray divider done");
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("input open while busy");

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for packet_queue_red_admission_top.
// Depends on pqra_pkg and the block's RTL; predicts each result and compares it.
`timescale 1ns / 1ps

module tb_top import pqra_pkg::*; ();

  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  qidx;
    logic [15:0] handle;
    logic [15:0] length;
  } request_t;

  typedef struct packed {
    logic [2:0]  st;
    logic [15:0] handle;
    logic [15:0] length;
    logic [2:0]  queue;
    logic [23:0] bytes;
    logic [31:0] limit_total;
    logic [31:0] early_total;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] operation = '0;
  logic [2:0] queue_index = '0;
  logic [15:0] packet_handle = '0;
  logic [15:0] packet_length = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] status;
  logic [15:0] out_handle;
  logic [15:0] out_length;
  logic [2:0] out_queue;
  logic [23:0] queue_byte_count;
  logic [31:0] limit_drop_total;
  logic [31:0] early_drop_total;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  packet_queue_red_admission_top dut (.*);

  // Predictor state: configuration and queue contents.
  logic [1:0]  m_policy;
  logic [23:0] m_limit, m_min, m_max;
  logic [15:0] m_prob, m_lfsr;
  logic [31:0] m_limit_drops, m_early_drops;
  logic [15:0] q_handles [NumQueues][$];
  logic [15:0] q_lengths [NumQueues][$];
  logic [23:0] q_bytes [NumQueues];

  request_t pending_requests[$];
  answer_t  expected_answers[$];
  int  idle_pct = 0, stall_pct = 0;
  int  errors = 0, quiet_cycles = 0;
  bit  hold_sender = 1'b0;

  initial forever #4 clk = ~clk;

  function automatic logic [31:0] sat_inc(logic [31:0] c);
    return (c == 32'hFFFFFFFF) ? c : c + 1;
  endfunction

  // Admission decision: 0 admit, 1 limit drop, 2 early drop.
  function automatic int judge_admission(logic [23:0] occ);
    logic [63:0] num;
    logic [31:0] chance;
    logic [15:0] s;
    if (m_policy == PolUnlim) return 0;
    if (m_policy != PolRed) return (m_limit > occ) ? 0 : 1;
    if (m_min > occ) return 0;
    if (m_max > occ) begin
      num = 64'(m_prob) * 64'(occ - m_min);
      chance = 32'(num / 64'(m_max - m_min));
    end else if (m_limit > occ) begin
      chance = 32'(m_prob);
    end else begin
      return 1;
    end
    s = m_lfsr >> 1;
    if (m_lfsr[0]) s = s ^ LfsrTaps;
    m_lfsr = s;
    return (32'(s) < chance) ? 2 : 0;
  endfunction

  function automatic void pop_head(int q, ref answer_t a);
    a.st = StDequeued;
    a.handle = q_handles[q].pop_front();
    a.length = q_lengths[q].pop_front();
    q_bytes[q] = (q_bytes[q] >= a.length) ? q_bytes[q] - a.length : 24'd0;
  endfunction

  // Computes the answer expected for one request and updates the queues.
  function automatic answer_t predict_answer(request_t r);
    answer_t a;
    int d;
    int q = r.qidx;
    bit live = 1'b1;
    a = '0;
    a.st = StEmpty;
    if (r.op == OpEnq) begin
      d = judge_admission(q_bytes[q]);
      if (d == 1) begin
        a.st = StLimitDrop;
        m_limit_drops = sat_inc(m_limit_drops);
      end else if (d == 2) begin
        a.st = StEarlyDrop;
        m_early_drops = sat_inc(m_early_drops);
      end else if (q_handles[q].size() >= RingDepth) begin
        a.st = StRingFull;
        m_limit_drops = sat_inc(m_limit_drops);
      end else if (25'(q_bytes[q]) + 25'(r.length) > 25'(ByteMax)) begin
        a.st = StLimitDrop;
        m_limit_drops = sat_inc(m_limit_drops);
      end else begin
        q_handles[q].push_back(r.handle);
        q_lengths[q].push_back(r.length);
        q_bytes[q] += r.length;
        a.st = StAccepted;
      end
    end else if (r.op == OpDeqNamed) begin
      if (q_handles[q].size() != 0) pop_head(q, a);
    end else if (r.op == OpDeqPrio) begin
      q = 0;
      live = 1'b0;
      for (int i = 0; i < NumQueues; i++) begin
        if (!live && q_handles[i].size() != 0) begin
          pop_head(i, a);
          q = i;
          live = 1'b1;
        end
      end
    end
    a.queue = 3'(q);
    a.bytes = live ? q_bytes[q] : 24'd0;
    a.limit_total = m_limit_drops;
    a.early_total = m_early_drops;
    return a;
  endfunction

  // Driver: presents pending requests, holding each one while stalled.
  always @(posedge clk) begin
    if (!rst) begin
      if (!in_valid || !in_stall) begin
        if (pending_requests.size() != 0 && !hold_sender &&
            $urandom_range(99) >= idle_pct) begin
          request_t r;
          r = pending_requests.pop_front();
          in_valid <= 1'b1;
          operation <= r.op;
          queue_index <= r.qidx;
          packet_handle <= r.handle;
          packet_length <= r.length;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Request accepted: predict its answer.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      request_t r;
      r = '{operation, queue_index, packet_handle, packet_length};
      expected_answers.push_back(predict_answer(r));
    end
  end

  // Monitor: compares each answer with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      answer_t got, want;
      got = '{status, out_handle, out_length, out_queue, queue_byte_count,
              limit_drop_total, early_drop_total};
      if (expected_answers.size() == 0) begin
        $display("%0t: unexpected answer %h", $time, got);
        errors++;
      end else begin
        want = expected_answers.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected %h actual %h", $time, want, got);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles in which no request is accepted and no answer taken.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_requests.size() != 0 || in_valid || expected_answers.size() != 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // Presents one register write and waits for its edge; the caller drops valid.
  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      RegPolicy: m_policy = value[1:0];
      RegLimit:  m_limit = value[23:0];
      RegMin:    m_min = value[23:0];
      RegMax:    m_max = value[23:0];
      RegProb:   m_prob = value[15:0];
      default: ;
    endcase
  endtask

  task automatic set_policy(logic [1:0] pol, logic [23:0] lim, logic [23:0] lo,
                            logic [23:0] hi, logic [15:0] prob);
    wait_drained();
    write_reg(RegPolicy, 32'(pol));
    write_reg(RegLimit, 32'(lim));
    write_reg(RegMin, 32'(lo));
    write_reg(RegMax, 32'(hi));
    write_reg(RegProb, 32'(prob));
    cfg_valid <= 1'b0;
  endtask

  task automatic add_request(logic [1:0] op, logic [2:0] q, logic [15:0] h,
                             logic [15:0] len);
    request_t r;
    r = '{op, q, h, len};
    pending_requests.push_back(r);
  endtask

  // Random mix: enqueues of mostly modest length at the given share, some dequeues and noise.
  task automatic add_random(int n, int enq_pct, int max_len);
    int k;
    logic [1:0] op;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < enq_pct) op = OpEnq;
      else if (k < enq_pct + (100 - enq_pct) / 2) op = OpDeqNamed;
      else if (k < 97) op = OpDeqPrio;
      else op = OpUnused;
      add_request(op, 3'($urandom_range(7)), 16'($urandom),
                  ($urandom_range(15) == 0) ? 16'($urandom) :
                  16'($urandom_range(max_len)));
    end
  endtask

  initial begin
    m_policy = PolUnlim; m_limit = ByteMax; m_min = '0; m_max = ByteMax;
    m_prob = '0; m_lfsr = LfsrSeed; m_limit_drops = '0; m_early_drops = '0;
    for (int i = 0; i < NumQueues; i++) q_bytes[i] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty service, extremes, zero length, unused operation.
    add_request(OpDeqPrio, 3'd0, 16'h0, 16'h0);
    add_request(OpDeqNamed, 3'd7, 16'hFFFF, 16'hFFFF);
    add_request(OpEnq, 3'd7, 16'hFFFF, 16'hFFFF);
    add_request(OpEnq, 3'd0, 16'h0000, 16'h0000);
    add_request(OpEnq, 3'd3, 16'hA5A5, 16'h5A5A);
    add_request(OpUnused, 3'd3, 16'h1234, 16'h4321);
    add_request(OpDeqPrio, 3'd5, 16'h0, 16'h0);
    add_request(OpDeqNamed, 3'd3, 16'h0, 16'h0);
    add_request(OpDeqNamed, 3'd7, 16'h0, 16'h0);
    add_request(OpDeqPrio, 3'd0, 16'h0, 16'h0);
    // Fill one ring past its depth with maximum lengths for ring full.
    for (int i = 0; i < RingDepth + 2; i++) add_request(OpEnq, 3'd1, 16'(i), 16'hFFFF);

    // Pause until all answers are in, then drain ring one.
    hold_sender = 1'b0;
    wait_drained();
    for (int i = 0; i < RingDepth + 1; i++) add_request(OpDeqNamed, 3'd1, 16'h0, 16'h0);

    // Unlimited policy: three maximum-length enqueues to queue two, then drain it.
    set_policy(PolUnlim, ByteMax, 24'd0, ByteMax, 16'd0);
    for (int i = 0; i < 3; i++) add_request(OpEnq, 3'd2, 16'(i), 16'hFFFF);
    wait_drained();
    hold_sender = 1'b1;
    for (int i = 0; i < RingDepth; i++) add_request(OpDeqNamed, 3'd2, 16'h0, 16'h0);
    hold_sender = 1'b0;

    // Phases over policies, idling and output stalls.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 72; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 72; end
        default: begin idle_pct = 12; stall_pct = 12; end
      endcase
      case (ph)
        0: set_policy(PolTail, 24'd20000, 24'd0, ByteMax, 16'd0);
        1: set_policy(PolRed, 24'd40000, 24'd2000, 24'd20000, 16'hFFFF);
        2: set_policy(PolToken, 24'd0, 24'd0, 24'd0, 16'd0);
        3: set_policy(PolRed, ByteMax, 24'd0, 24'd1, 16'h8000);
        4: set_policy(PolRed, 24'd15000, 24'd0, 24'd30000, 16'h4000);
        5: set_policy(PolUnlim, ByteMax, ByteMax, ByteMax, 16'hFFFF);
        6: set_policy(PolRed, 24'd60000, 24'd1000, 24'd50000, 16'hC000);
        default: set_policy(PolTail, ByteMax, 24'd5, 24'd3, 16'h0001);
      endcase
      add_random(70, 60, 4000);
      if (ph == 4) begin
        wait_drained();
        add_random(10, 50, 4000);
      end
    end

    wait_drained();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
